// ===== rtl/core/lobm_pkg.sv =====
// Package for the limit order book matcher: book entry and chain command
// types, result kinds, default book depth and the price then id priority compare.
// No dependencies.
package lobm_pkg;

   localparam int ORDERS_PER_SIDE_DEF = 32;

   typedef struct packed {
      logic        valid;
      logic [31:0] price;
      logic [31:0] id;
      logic [23:0] qty;
   } lobm_entry_type;

   typedef enum logic [2:0] {
      CH_HOLD,
      CH_POP,
      CH_INSERT,
      CH_HEAD_QTY,
      CH_REPOST
   } lobm_op_type;

   typedef struct packed {
      lobm_op_type op;
      logic [31:0] price;
      logic [31:0] id;
      logic [23:0] qty;
   } lobm_cmd_type;

   typedef enum logic [1:0] {
      KIND_TRADE   = 2'd0,
      KIND_RESTED  = 2'd1,
      KIND_NONE    = 2'd2,
      KIND_DROPPED = 2'd3
   } lobm_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_REST,
      ST_STATUS
   } lobm_state_type;

   // True when order a has priority over order b on the given side
   function automatic logic lobm_better(input logic is_ask,
                                        input logic [31:0] a_price,
                                        input logic [31:0] a_id,
                                        input logic [31:0] b_price,
                                        input logic [31:0] b_id);
      logic res;
      if (a_price == b_price) begin
         res = a_id < b_id;
      end else if (is_ask) begin
         res = a_price < b_price;
      end else begin
         res = a_price > b_price;
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/lobm_cell.sv =====
// One slot of a sorted book side. Holds one resting order and exchanges it
// with its neighbors on insert and pop. Depends on lobm_pkg.
module lobm_cell import lobm_pkg::*; #(
   parameter bit IS_ASK  = 1'b0,
   parameter bit IS_HEAD = 1'b0
) (
   input  logic           clock,
   input  logic           reset,
   input  lobm_cmd_type   cmd,
   input  lobm_entry_type left_entry,
   input  logic           left_ahead,
   input  lobm_entry_type right_entry,
   output lobm_entry_type entry,
   output logic           ahead,
   output logic           match
);

   lobm_entry_type entry_ff, entry_in;

   // new order sorts ahead of this slot (empty slots sort last)
   assign ahead = !entry_ff.valid ||
                  lobm_better(IS_ASK, cmd.price, cmd.id, entry_ff.price, entry_ff.id);
   assign match  = entry_ff.valid && entry_ff.price == cmd.price && entry_ff.id == cmd.id;
   assign entry  = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         CH_POP: begin
            entry_in = right_entry;
         end
         CH_INSERT: begin
            if (ahead) begin
               if (left_ahead) begin
                  entry_in = left_entry;
               end else begin
                  entry_in = '{valid: 1'b1, price: cmd.price, id: cmd.id, qty: cmd.qty};
               end
            end
         end
         CH_HEAD_QTY: begin
            if (IS_HEAD) begin
               entry_in.qty = cmd.qty;
            end
         end
         CH_REPOST: begin
            if (match) begin
               entry_in.qty = cmd.qty;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

// ===== rtl/core/lobm_chain.sv =====
// One side of the book as a row of sorted cells, best order in cell 0.
// Depends on lobm_pkg and lobm_cell.
module lobm_chain import lobm_pkg::*; #(
   parameter bit IS_ASK          = 1'b0,
   parameter int ORDERS_PER_SIDE = ORDERS_PER_SIDE_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  lobm_cmd_type   cmd,
   output lobm_entry_type head,
   output logic           hit,
   output logic           full
);

   lobm_entry_type entries [ORDERS_PER_SIDE];
   logic [ORDERS_PER_SIDE-1:0] aheads;
   logic [ORDERS_PER_SIDE-1:0] hit_bits;

   for (genvar i = 0; i < ORDERS_PER_SIDE; i++) begin : g_cell
      lobm_entry_type left_e, right_e;
      logic           left_b;
      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_b = 1'b0;
      end else begin : g_mid
         assign left_e = entries[i-1];
         assign left_b = aheads[i-1];
      end
      if (i == ORDERS_PER_SIDE - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_notlast
         assign right_e = entries[i+1];
      end
      lobm_cell #(.IS_ASK(IS_ASK), .IS_HEAD(i == 0)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_e),
         .left_ahead  (left_b),
         .right_entry (right_e),
         .entry       (entries[i]),
         .ahead       (aheads[i]),
         .match       (hit_bits[i])
      );
   end

   assign head = entries[0];
   assign hit  = |hit_bits;
   assign full = entries[ORDERS_PER_SIDE-1].valid;

endmodule

// ===== rtl/core/limit_order_book_matcher.sv =====
// Limit order book matcher, price then id priority, two sorted cell chains.
// Each accepted order is sequenced as one trade item per cross at the opposite
// head, a match step that finds no cross, a rest step and then the status item,
// which is the last item of the order.
// One order at a time: a new one is accepted only in idle; a result waiting on
// rsp_ready stalls the sequencer. Synchronous reset empties the book.
module limit_order_book_matcher import lobm_pkg::*; #(
   parameter int ORDERS_PER_SIDE = ORDERS_PER_SIDE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_order_side,
   input  logic [31:0] req_order_price,
   input  logic [23:0] req_order_quantity,
   input  logic [31:0] req_order_id,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_result_kind,
   output logic [31:0] rsp_contra_id,
   output logic [23:0] rsp_trade_quantity,
   output logic [31:0] rsp_trade_price,
   output logic [23:0] rsp_rested_quantity,
   output logic [31:0] rsp_best_bid,
   output logic [31:0] rsp_best_ask,
   output logic [32:0] rsp_mid_twice,
   output logic        rsp_is_last
);

   lobm_state_type state_ff, state_in;
   logic           side_ff, side_in;
   logic [31:0]    price_ff, price_in;
   logic [23:0]    qty_ff, qty_in;
   logic [31:0]    id_ff, id_in;
   lobm_kind_type  kind_ff, kind_in;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     kind_o_ff, kind_o_in;
   logic [31:0]    cid_ff, cid_in;
   logic [23:0]    tq_ff, tq_in;
   logic [31:0]    tp_ff, tp_in;
   logic [23:0]    rq_ff, rq_in;
   logic [31:0]    bb_ff, bb_in;
   logic [31:0]    ba_ff, ba_in;
   logic [32:0]    mid_ff, mid_in;
   logic           last_ff, last_in;

   lobm_cmd_type   bid_cmd, ask_cmd;
   lobm_entry_type bid_head, ask_head, opp_head;
   logic           bid_hit, ask_hit, bid_full, ask_full;
   logic           out_free, crosses, own_hit, own_full;
   logic [23:0]    tq;

   lobm_chain #(.IS_ASK(1'b0), .ORDERS_PER_SIDE(ORDERS_PER_SIDE)) u_bids (
      .clock (clock), .reset (reset), .cmd (bid_cmd),
      .head  (bid_head), .hit (bid_hit), .full (bid_full)
   );

   lobm_chain #(.IS_ASK(1'b1), .ORDERS_PER_SIDE(ORDERS_PER_SIDE)) u_asks (
      .clock (clock), .reset (reset), .cmd (ask_cmd),
      .head  (ask_head), .hit (ask_hit), .full (ask_full)
   );

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign opp_head = side_ff ? bid_head : ask_head;
   assign own_hit  = side_ff ? ask_hit : bid_hit;
   assign own_full = side_ff ? ask_full : bid_full;
   assign crosses  = opp_head.valid && qty_ff != '0 &&
                     (side_ff ? (price_ff <= opp_head.price) : (price_ff >= opp_head.price));
   assign tq       = (opp_head.qty < qty_ff) ? opp_head.qty : qty_ff;

   // sequencer: match at the opposite head, rest, then status item
   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      price_in = price_ff;
      qty_in   = qty_ff;
      id_in    = id_ff;
      kind_in  = kind_ff;
      bid_cmd  = '{op: CH_HOLD, price: price_ff, id: id_ff, qty: qty_ff};
      ask_cmd  = '{op: CH_HOLD, price: price_ff, id: id_ff, qty: qty_ff};
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      kind_o_in = kind_o_ff;
      cid_in   = cid_ff;
      tq_in    = tq_ff;
      tp_in    = tp_ff;
      rq_in    = rq_ff;
      bb_in    = bb_ff;
      ba_in    = ba_ff;
      mid_in   = mid_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               side_in  = req_order_side;
               price_in = req_order_price;
               qty_in   = req_order_quantity;
               id_in    = req_order_id;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            if (!crosses) begin
               state_in = ST_REST;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_o_in = KIND_TRADE;
               cid_in   = opp_head.id;
               tq_in    = tq;
               tp_in    = opp_head.price;
               rq_in    = '0;
               bb_in    = '0;
               ba_in    = '0;
               mid_in   = '0;
               last_in  = 1'b0;
               qty_in   = qty_ff - tq;
               if (side_ff) begin
                  bid_cmd.op  = (opp_head.qty == tq) ? CH_POP : CH_HEAD_QTY;
                  bid_cmd.qty = opp_head.qty - tq;
               end else begin
                  ask_cmd.op  = (opp_head.qty == tq) ? CH_POP : CH_HEAD_QTY;
                  ask_cmd.qty = opp_head.qty - tq;
               end
            end
         end
         ST_REST: begin
            state_in = ST_STATUS;
            if (qty_ff == '0) begin
               kind_in = KIND_NONE;
            end else if (own_hit || !own_full) begin
               kind_in = KIND_RESTED;
               if (side_ff) begin
                  ask_cmd.op = own_hit ? CH_REPOST : CH_INSERT;
               end else begin
                  bid_cmd.op = own_hit ? CH_REPOST : CH_INSERT;
               end
            end else begin
               kind_in = KIND_DROPPED;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_o_in = kind_ff;
               cid_in   = '0;
               tq_in    = '0;
               tp_in    = '0;
               rq_in    = qty_ff;
               bb_in    = bid_head.valid ? bid_head.price : '0;
               ba_in    = ask_head.valid ? ask_head.price : '0;
               mid_in   = (bb_in == '0 || ba_in == '0) ? '0 : {1'b0, bb_in} + {1'b0, ba_in};
               last_in  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      side_ff   <= side_in;
      price_ff  <= price_in;
      qty_ff    <= qty_in;
      id_ff     <= id_in;
      kind_ff   <= kind_in;
      kind_o_ff <= kind_o_in;
      cid_ff    <= cid_in;
      tq_ff     <= tq_in;
      tp_ff     <= tp_in;
      rq_ff     <= rq_in;
      bb_ff     <= bb_in;
      ba_ff     <= ba_in;
      mid_ff    <= mid_in;
      last_ff   <= last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_result_kind     = kind_o_ff;
   assign rsp_contra_id       = cid_ff;
   assign rsp_trade_quantity  = tq_ff;
   assign rsp_trade_price     = tp_ff;
   assign rsp_rested_quantity = rq_ff;
   assign rsp_best_bid        = bb_ff;
   assign rsp_best_ask        = ba_ff;
   assign rsp_mid_twice       = mid_ff;
   assign rsp_is_last         = last_ff;

   // resting book is never crossed between orders
   a_not_crossed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && bid_head.valid && ask_head.valid)
         |-> (bid_head.price < ask_head.price))
      else $error("book crossed while idle");

   // a trade item never closes an order
   a_trade_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind == KIND_TRADE) |-> !rsp_is_last)
      else $error("trade item flagged last");

   // an accepted order leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_MATCH))
      else $error("accepted order not matched");

endmodule
